// ----- src/lfo_modulated_delay_flanger_defines.svh -----
// Assertion macros shared by the flanger RTL.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef LFO_MODULATED_DELAY_FLANGER_DEFINES_SVH
`define LFO_MODULATED_DELAY_FLANGER_DEFINES_SVH

// Checked on every clock edge outside reset
`define FLG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every clock edge, reset included
`define FLG_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/flg_pkg.sv -----
// Shared types and constants of the flanger.
// No dependencies; used by flg_if, the top level, flg_sine_rom and flg_mac.
package flg_pkg;

   // Sample and register widths
   localparam int SAMPLE_W   = 16;
   localparam int CSR_DATA_W = 22;
   localparam int CSR_IDX_W  = 3;
   localparam int DLY_W      = 28;   // base*2^15 + (1+sin)*depth*2^15

   // pi/2 in Q30, seed of the sine table series
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Gain limits in Q1.15
   localparam logic [14:0] FB_MAX  = 15'd31129;
   localparam logic [15:0] MIX_MAX = 16'd32768;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_STEP    = 3'd0,
      CSR_BASE_DELAY    = 3'd1,
      CSR_DEPTH         = 3'd2,
      CSR_FEEDBACK_GAIN = 3'd3,
      CSR_MIX_GAIN      = 3'd4
   } flg_csr_index_type;

   // One request to the shared multiply, round and add unit
   typedef struct packed {
      logic                en;
      logic signed [16:0]  a;
      logic [15:0]         b;
      logic signed [15:0]  e;
   } flg_mac_req_type;

endpackage

// ----- src/flg_if.sv -----
// Handshake channels of the flanger: sample requests and flanged results.
// Uses flg_pkg for the sample width.
interface flg_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [flg_pkg::SAMPLE_W-1:0] sample_in;
   logic                                block_last_in;

   modport source (output valid, sample_in, block_last_in, input ready);
   modport sink   (input valid, sample_in, block_last_in, output ready);
endinterface

interface flg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [flg_pkg::SAMPLE_W-1:0] sample_out;
   logic                                block_last_out;

   modport source (output valid, sample_out, block_last_out, input ready);
   modport sink   (input valid, sample_out, block_last_out, output ready);
endinterface

// ----- src/lfo_modulated_delay_flanger.sv -----
// Top level of the flanger: sequencer, delay line, LFO and config registers.
// Uses flg_pkg, flg_if, flg_ram, flg_sine_rom, flg_mac and the assertion header.
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    sample_in[15:0] signed, block_last_in
//   rsp_chan  out  valid/ready    sample_out[15:0] signed, block_last_out
//   csr_*     in   csr_wr_en      csr_index[2:0], csr_wr_data[21:0]
//
// An item passes through S_ROM, S_DLY, S_MOD, S_POS, S_RD0, S_RD1, S_INTERP, S_FB, S_WET
// and S_OUT before the next is accepted; S_MOD repeats once for each reduction of the delay
// by the line length; the final step also waits while the previous result is still held.
// One multiplier does interpolation, feedback and mix in turn; the RAM read port
// fetches both taps in turn. Reset is synchronous; no clearing pass, unwritten slots read 0.
`include "lfo_modulated_delay_flanger_defines.svh"

module lfo_modulated_delay_flanger #(
   parameter int DELAY_DEPTH     = 4096,
   parameter int SINE_TABLE_SIZE = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   flg_req_if.sink                            req_chan,
   flg_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [flg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [flg_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int AW  = $clog2(DELAY_DEPTH);
   localparam int PW  = AW + 15;
   localparam int WW  = (PW + 1 > flg_pkg::DLY_W) ? PW + 1 : flg_pkg::DLY_W;
   localparam int QTR = SINE_TABLE_SIZE / 4;
   localparam int IW  = $clog2(4 * QTR);
   localparam int RW  = $clog2(QTR + 1);

   localparam logic [AW:0] DEPTH_VEC = (AW+1)'(DELAY_DEPTH);
   localparam logic [PW:0] SPAN      = {DEPTH_VEC, 15'd0};
   localparam logic [AW-1:0] LAST_SLOT = AW'(DELAY_DEPTH - 1);
   localparam logic [IW:0] SIN_Q1   = (IW+1)'(QTR);
   localparam logic [IW:0] SIN_HALF = (IW+1)'(2 * QTR);
   localparam logic [IW:0] SIN_Q3   = (IW+1)'(3 * QTR);
   localparam logic [IW:0] SIN_FULL = (IW+1)'(4 * QTR);

   typedef enum logic [3:0] {
      S_IDLE, S_ROM, S_DLY, S_MOD, S_POS, S_RD0, S_RD1,
      S_INTERP, S_FB, S_WET, S_OUT
   } state_type;

   // Configuration registers
   logic [21:0] phase_step_ff;
   logic [9:0]  base_delay_ff;
   logic [9:0]  depth_ff;
   logic [14:0] feedback_gain_ff;
   logic [15:0] mix_gain_ff;

   // Sequencer and datapath registers
   state_type   state_ff;
   logic [AW-1:0] wi_ff;
   logic        wrap_ff;
   logic [31:0] phase_ff;
   logic [15:0] x_ff;
   logic        last_ff;
   logic [RW-1:0] rom_addr_ff;
   logic        sneg_ff;
   logic [WW-1:0] dly_ff;
   logic [AW-1:0] r0_ff;
   logic [AW-1:0] r1_ff;
   logic [14:0] f_ff;
   logic        v0_ff;
   logic        v1_ff;
   logic [15:0] d0_ff;
   logic [15:0] delayed_ff;
   logic        rsp_valid_ff;
   logic [15:0] out_sample_ff;
   logic        out_last_ff;

   // Combinational signals
   logic [32+IW:0] ph_prod;
   logic [IW:0]    sidx;
   logic [IW:0]    sfold;
   logic [14:0]    rom_q;
   logic [16:0]    sine_off;
   logic [26:0]    dly_prod;
   logic [27:0]    dly_sum;
   logic [WW:0]    pos_diff;
   logic [WW:0]    pos_wrap;
   logic [PW-1:0]  pos;
   logic [AW-1:0]  ram_rd_addr;
   logic [15:0]    ram_q;
   logic [15:0]    d1;
   logic [14:0]    fb_use;
   logic [15:0]    mx_use;
   logic [15:0]    mac_q;
   flg_pkg::flg_mac_req_type mac_req;

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff    <= 22'd44739;
         base_delay_ff    <= 10'd48;
         depth_ff         <= 10'd96;
         feedback_gain_ff <= 15'd0;
         mix_gain_ff      <= 16'd16384;
      end else if (csr_wr_en) begin
         unique case (flg_pkg::flg_csr_index_type'(csr_index))
            flg_pkg::CSR_PHASE_STEP:    phase_step_ff    <= csr_wr_data[21:0];
            flg_pkg::CSR_BASE_DELAY:    base_delay_ff    <= csr_wr_data[9:0];
            flg_pkg::CSR_DEPTH:         depth_ff         <= csr_wr_data[9:0];
            flg_pkg::CSR_FEEDBACK_GAIN: feedback_gain_ff <= csr_wr_data[14:0];
            flg_pkg::CSR_MIX_GAIN:      mix_gain_ff      <= csr_wr_data[15:0];
            default: ;
         endcase
      end
   end

   // Gains clamped to their limits
   assign fb_use = (feedback_gain_ff > flg_pkg::FB_MAX) ? flg_pkg::FB_MAX : feedback_gain_ff;
   assign mx_use = (mix_gain_ff > flg_pkg::MIX_MAX) ? flg_pkg::MIX_MAX : mix_gain_ff;

   // Sine table index from the phase, folded into the first quadrant
   always_comb begin
      ph_prod = phase_ff * SIN_FULL;
      sidx    = ph_prod[32 +: IW+1];
      priority if (sidx < SIN_Q1) begin
         sfold = sidx;
      end else if (sidx < SIN_HALF) begin
         sfold = SIN_HALF - sidx;
      end else if (sidx < SIN_Q3) begin
         sfold = sidx - SIN_HALF;
      end else begin
         sfold = SIN_FULL - sidx;
      end
   end

   // Delay in Q.15: base + (1 + sin) * depth
   assign sine_off = sneg_ff ? (17'd32768 - {2'b0, rom_q}) : (17'd32768 + {2'b0, rom_q});
   assign dly_prod = sine_off * depth_ff;
   assign dly_sum  = {3'b0, base_delay_ff, 15'd0} + {1'b0, dly_prod};

   // Read position behind the write slot, wrapped into the line
   always_comb begin
      pos_diff = (WW+1)'({wi_ff, 15'd0}) - (WW+1)'(dly_ff);
      pos_wrap = pos_diff + (WW+1)'(SPAN);
      pos      = pos_diff[WW] ? pos_wrap[PW-1:0] : pos_diff[PW-1:0];
   end

   // Second tap; slots not yet written read as zero
   assign d1          = v1_ff ? ram_q : 16'd0;
   assign ram_rd_addr = (state_ff == S_RD1) ? r1_ff : r0_ff;

   // Operand select for the shared unit
   always_comb begin
      mac_req = '0;
      unique case (state_ff)
         S_INTERP: begin
            mac_req.en = 1'b1;
            mac_req.a  = {d1[15], d1} - {d0_ff[15], d0_ff};
            mac_req.b  = {1'b0, f_ff};
            mac_req.e  = d0_ff;
         end
         S_FB: begin
            mac_req.en = 1'b1;
            mac_req.a  = {mac_q[15], mac_q};
            mac_req.b  = {1'b0, fb_use};
            mac_req.e  = x_ff;
         end
         S_WET: begin
            mac_req.en = 1'b1;
            mac_req.a  = {delayed_ff[15], delayed_ff} - {x_ff[15], x_ff};
            mac_req.b  = mx_use;
            mac_req.e  = x_ff;
         end
         default: ;
      endcase
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wi_ff        <= '0;
         wrap_ff      <= 1'b0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // S_OUT handles the taken result itself
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  x_ff        <= req_chan.sample_in;
                  last_ff     <= req_chan.block_last_in;
                  rom_addr_ff <= sfold[RW-1:0];
                  sneg_ff     <= (sidx >= SIN_HALF);
                  state_ff    <= S_ROM;
               end
            end
            S_ROM: begin
               state_ff <= S_DLY;
            end
            S_DLY: begin
               dly_ff   <= WW'(dly_sum);
               state_ff <= S_MOD;
            end
            S_MOD: begin
               if (dly_ff >= WW'(SPAN)) begin
                  dly_ff <= dly_ff - WW'(SPAN);
               end else begin
                  state_ff <= S_POS;
               end
            end
            S_POS: begin
               r0_ff    <= pos[PW-1:15];
               f_ff     <= pos[14:0];
               state_ff <= S_RD0;
            end
            S_RD0: begin
               v0_ff    <= wrap_ff || (r0_ff < wi_ff);
               r1_ff    <= (r0_ff == LAST_SLOT) ? '0 : r0_ff + 1'b1;
               state_ff <= S_RD1;
            end
            S_RD1: begin
               d0_ff    <= v0_ff ? ram_q : 16'd0;
               v1_ff    <= wrap_ff || (r1_ff < wi_ff);
               state_ff <= S_INTERP;
            end
            S_INTERP: begin
               state_ff <= S_FB;
            end
            S_FB: begin
               delayed_ff <= mac_q;
               state_ff   <= S_WET;
            end
            S_WET: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  out_sample_ff <= mac_q;
                  out_last_ff   <= last_ff;
                  phase_ff      <= phase_ff + {10'd0, phase_step_ff};
                  if (wi_ff == LAST_SLOT) begin
                     wi_ff   <= '0;
                     wrap_ff <= 1'b1;
                  end else begin
                     wi_ff <= wi_ff + 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Delay line: taps read in S_RD0/S_RD1, feedback sample written in S_WET
   flg_ram #(
      .WIDTH (16),
      .DEPTH (DELAY_DEPTH)
   ) u_delay_line (
      .clock   (clock),
      .wr_en   (state_ff == S_WET),
      .wr_addr (wi_ff),
      .wr_data (mac_q),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_q)
   );

   flg_sine_rom #(
      .QTR (QTR)
   ) u_sine_rom (
      .clock (clock),
      .addr  (rom_addr_ff),
      .data  (rom_q)
   );

   flg_mac u_mac (
      .clock  (clock),
      .req    (mac_req),
      .result (mac_q)
   );

   // Channel outputs
   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.sample_out     = out_sample_ff;
   assign rsp_chan.block_last_out = out_last_ff;

   // Checks
   `FLG_ASSERT(a_wi_range, ({1'b0, wi_ff} < DEPTH_VEC), "write index past line end")
   `FLG_ASSERT(a_mod_done, (state_ff == S_POS) |-> (dly_ff < WW'(SPAN)), "delay not reduced")
   `FLG_ASSERT(a_busy_after_accept, (req_chan.valid && req_chan.ready) |=> !req_chan.ready, "ready after accept")
   `FLG_ASSERT(a_rsp_source, $rose(rsp_chan.valid) |-> $past(state_ff == S_OUT), "result not from final step")

endmodule

// ----- src/flg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module flg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/flg_sine_rom.sv -----
// Quarter-wave sine table, built at elaboration, with registered read.
// Uses flg_pkg for the pi/2 seed of the series.
module flg_sine_rom #(
   parameter int QTR = 64
) (
   input  logic                     clock,
   input  logic [$clog2(QTR+1)-1:0] addr,
   output logic [14:0]              data
);

   logic [14:0] tbl [QTR+1];
   logic [14:0] data_ff;

   // Entry k = round(32767 * sin(pi/2 * k / QTR)), odd Taylor series to x^15
   for (genvar k = 0; k <= QTR; k++) begin : g_entry
      localparam logic [63:0] X  = flg_pkg::HALF_PI_Q30 * 64'(k) / QTR;
      localparam logic [63:0] T1 = ((((X  * X) >> 30) * X) >> 30) / 64'd6;
      localparam logic [63:0] T2 = ((((T1 * X) >> 30) * X) >> 30) / 64'd20;
      localparam logic [63:0] T3 = ((((T2 * X) >> 30) * X) >> 30) / 64'd42;
      localparam logic [63:0] T4 = ((((T3 * X) >> 30) * X) >> 30) / 64'd72;
      localparam logic [63:0] T5 = ((((T4 * X) >> 30) * X) >> 30) / 64'd110;
      localparam logic [63:0] T6 = ((((T5 * X) >> 30) * X) >> 30) / 64'd156;
      localparam logic [63:0] T7 = ((((T6 * X) >> 30) * X) >> 30) / 64'd210;
      localparam logic signed [63:0] SUM = $signed(X) - $signed(T1) + $signed(T2)
         - $signed(T3) + $signed(T4) - $signed(T5) + $signed(T6) - $signed(T7);
      localparam logic signed [63:0] CLAMP = (SUM < 64'sd0) ? 64'sd0 :
         ((SUM > 64'sd1073741824) ? 64'sd1073741824 : SUM);
      localparam logic [63:0] VAL = (64'(CLAMP) * 64'd32767 + 64'd536870912) >> 30;
      assign tbl[k] = VAL[14:0];
   end

   always_ff @(posedge clock) begin
      data_ff <= tbl[addr];
   end

   assign data = data_ff;

endmodule

// ----- src/flg_mac.sv -----
// Shared arithmetic unit: sat16(e + round_q15(a * b)), registered result.
// Uses flg_pkg for the request struct.
module flg_mac (
   input  logic                     clock,
   input  flg_pkg::flg_mac_req_type req,
   output logic [15:0]              result
);

   logic signed [33:0] prod;
   logic signed [33:0] biased;
   logic signed [19:0] total;
   logic [15:0]        sat;
   logic [15:0]        result_ff;

   // Multiply, round half up, add, saturate
   always_comb begin
      prod   = $signed(req.a) * $signed({1'b0, req.b});
      biased = prod + 34'sd16384;
      total  = 20'($signed(biased[33:15])) + 20'(req.e);
      priority if (total > 20'sd32767) begin
         sat = 16'h7FFF;
      end else if (total < -20'sd32768) begin
         sat = 16'h8000;
      end else begin
         sat = total[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req.en) begin
         result_ff <= sat;
      end
   end

   assign result = result_ff;

endmodule
